FILE: sv/srrs_pkg.sv
// Shared constants for the strand round robin scheduler.
// Request, status, action and lifecycle codes plus parameter defaults; no dependencies.
`default_nettype none
package srrs_pkg;

  localparam int unsigned NUM_STRANDS_DEF    = 16;
  localparam int unsigned OP_DEPTH_DEF       = 8;
  localparam int unsigned RESERVED_DEPTH_DEF = 8;

  localparam logic [3:0] OP_LIMIT_RST = 4'd8;

  localparam logic [2:0] REQ_POST     = 3'd0;
  localparam logic [2:0] REQ_COMPLETE = 3'd1;
  localparam logic [2:0] REQ_QUIESCE  = 3'd2;
  localparam logic [2:0] REQ_RUN      = 3'd3;
  localparam logic [2:0] REQ_GEN_ADV  = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_STOPPING   = 3'd1;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd2;
  localparam logic [2:0] ST_RING_EMPTY = 3'd3;
  localparam logic [2:0] ST_CPL_OVF    = 3'd4;

  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_INVOKE      = 3'd1;
  localparam logic [2:0] ACT_STALE       = 3'd2;
  localparam logic [2:0] ACT_CLEANUP     = 3'd3;
  localparam logic [2:0] ACT_COMPLETE    = 3'd4;
  localparam logic [2:0] ACT_STALE_CPL   = 3'd5;

  localparam logic [2:0] LC_IDLE      = 3'd0;
  localparam logic [2:0] LC_SCHEDULED = 3'd1;
  localparam logic [2:0] LC_RUNNING   = 3'd2;
  localparam logic [2:0] LC_CLOSING   = 3'd3;
  localparam logic [2:0] LC_STOPPED   = 3'd4;

  localparam logic KIND_POST       = 1'b0;
  localparam logic KIND_COMPLETION = 1'b1;

  // op entry: kind, error, generation stamp, handle
  localparam int unsigned OP_W = 49;

endpackage
`default_nettype wire

FILE: sv/srrs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module srrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: sv/strand_round_robin_scheduler_unit.sv
// Top level of the strand round robin scheduler: control sequencer and state tables.
// Depends on srrs_pkg and srrs_ram (strand table, ready ring, op store).
//
// Each request takes one item per transfer on start_i while busy_o is low and
// returns one result, strobed by done_o for one cycle. A post, completion,
// quiesce or generation advance runs a strand table read, then modify and
// write back; a run goes through ring read, strand table read, op store read
// and write back; a run on an empty ring is answered without a table read. The
// result cannot be held off. The strand table has per-entry valid bits, so no
// clearing pass is needed after reset; op_limit is written with op_limit_we_i.
`default_nettype none
module strand_round_robin_scheduler_unit #(
  parameter int unsigned NUM_STRANDS    = srrs_pkg::NUM_STRANDS_DEF,
  parameter int unsigned OP_DEPTH       = srrs_pkg::OP_DEPTH_DEF,
  parameter int unsigned RESERVED_DEPTH = srrs_pkg::RESERVED_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        op_limit_we_i,
  input  wire logic [3:0]  op_limit_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [3:0]  strand_id_i,
  input  wire logic [31:0] op_handle_i,
  input  wire logic [7:0]  op_generation_i,
  input  wire logic [7:0]  completion_error_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [2:0]       action_o,
  output logic [3:0]       run_strand_o,
  output logic [31:0]      run_handle_o,
  output logic [7:0]       run_error_o,
  output logic [2:0]       strand_status_o,
  output logic             duplicate_fault_o
);

  localparam int unsigned SLOTS = OP_DEPTH + RESERVED_DEPTH;
  localparam int unsigned SW    = NUM_STRANDS > 1 ? $clog2(NUM_STRANDS) : 1;
  localparam int unsigned RCW   = $clog2(NUM_STRANDS + 1);
  localparam int unsigned PW    = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned OW    = $clog2(OP_DEPTH + 1);
  localparam int unsigned OPD   = NUM_STRANDS * SLOTS;
  localparam int unsigned OAW   = OPD > 1 ? $clog2(OPD) : 1;

  typedef struct packed {
    logic [2:0]    lc;
    logic          closing;
    logic          pending;
    logic          in_ring;
    logic [7:0]    gen;
    logic [OW-1:0] outst;
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [CW-1:0] cnt;
  } strand_t;

  localparam int unsigned STW = $bits(strand_t);

  typedef enum logic [1:0] {S_IDLE, S_RING, S_STRAND, S_OP} state_e;

  state_e               state_q, state_d;
  logic [2:0]           req_q;
  logic [3:0]           sid_q;
  logic [31:0]          handle_q;
  logic [7:0]           gen_q, err_q;
  logic [SW-1:0]        t_q;
  strand_t              ent_q;
  logic [SW-1:0]        ring_head_q, ring_head_d;
  logic [RCW-1:0]       ring_cnt_q, ring_cnt_d;
  logic                 fault_q, fault_d;
  logic [3:0]           op_limit_q;
  logic [NUM_STRANDS-1:0] vld_q;
  logic                 vld_rd_q;

  logic                 done_q, done_d;
  logic [2:0]           status_q, status_d, action_q, action_d, sstat_q, sstat_d;
  logic [3:0]           rstrand_q, rstrand_d;
  logic [31:0]          rhandle_q, rhandle_d;
  logic [7:0]           rerr_q, rerr_d;

  logic                 st_we;
  logic [SW-1:0]        st_waddr, st_raddr;
  logic [STW-1:0]       st_rdata;
  strand_t              st_rd, ent_n;
  logic                 ring_we;
  logic [SW-1:0]        ring_waddr, ring_raddr, ring_rdata;
  logic                 op_we;
  logic [OAW-1:0]       op_waddr, op_raddr;
  logic [srrs_pkg::OP_W-1:0] op_wdata, op_rdata;

  logic                 accept;
  logic                 sid_ok;
  logic [SW-1:0]        sid_idx;
  logic                 push_req, have, fresh;
  logic [SW-1:0]        head_base;
  logic [RCW-1:0]       cnt_base;
  logic [RCW:0]         tail_sum;
  logic [31:0]          t_ext;

  srrs_ram #(.WIDTH(STW), .DEPTH(NUM_STRANDS)) u_strand_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(ent_n),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  srrs_ram #(.WIDTH(SW), .DEPTH(NUM_STRANDS)) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(t_q),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  srrs_ram #(.WIDTH(srrs_pkg::OP_W), .DEPTH(OPD)) u_op_ram (
    .clk_i  (clk_i),
    .we_i   (op_we),
    .waddr_i(op_waddr),
    .wdata_i(op_wdata),
    .raddr_i(op_raddr),
    .rdata_o(op_rdata)
  );

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign sid_ok  = (32'(sid_q) < NUM_STRANDS);
  assign sid_idx = SW'(sid_q);
  // an entry never written reads as its reset value
  assign st_rd   = vld_rd_q ? strand_t'(st_rdata) : '0;
  assign t_ext   = 32'(t_q);

  always_comb begin
    state_d     = state_q;
    ring_head_d = ring_head_q;
    ring_cnt_d  = ring_cnt_q;
    fault_d     = fault_q;
    done_d      = 1'b0;
    status_d    = srrs_pkg::ST_OK;
    action_d    = srrs_pkg::ACT_NONE;
    rstrand_d   = '0;
    rhandle_d   = '0;
    rerr_d      = '0;
    sstat_d     = srrs_pkg::LC_IDLE;
    st_we       = 1'b0;
    st_waddr    = sid_idx;
    st_raddr    = SW'(strand_id_i);
    ring_we     = 1'b0;
    ring_waddr  = '0;
    ring_raddr  = ring_head_q;
    op_we       = 1'b0;
    op_waddr    = OAW'(sid_idx) * OAW'(SLOTS) + OAW'(st_rd.tail);
    op_wdata    = {srrs_pkg::KIND_POST, 8'd0, st_rd.gen, handle_q};
    op_raddr    = OAW'(t_q) * OAW'(SLOTS) + OAW'(st_rd.head);
    ent_n       = st_rd;
    push_req    = 1'b0;
    have        = 1'b0;
    fresh       = 1'b0;
    head_base   = ring_head_q;
    cnt_base    = ring_cnt_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == srrs_pkg::REQ_RUN) begin
            if (ring_cnt_q == '0) begin
              done_d   = 1'b1;
              status_d = srrs_pkg::ST_RING_EMPTY;
            end else begin
              state_d = S_RING;
            end
          end else begin
            state_d = S_STRAND;
          end
        end
      end
      S_RING: begin
        st_raddr = ring_rdata;
        state_d  = S_STRAND;
      end
      S_STRAND: begin
        if (req_q == srrs_pkg::REQ_RUN) begin
          state_d = S_OP;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          if (sid_ok) begin
            st_we = 1'b1;
            case (req_q)
              srrs_pkg::REQ_POST: begin
                if (st_rd.closing) begin
                  status_d = srrs_pkg::ST_STOPPING;
                end else if (32'(st_rd.outst) >= 32'(op_limit_q) ||
                             32'(st_rd.outst) >= OP_DEPTH ||
                             32'(st_rd.cnt) >= SLOTS) begin
                  status_d = srrs_pkg::ST_QUEUE_FULL;
                end else begin
                  op_we       = 1'b1;
                  ent_n.tail  = (st_rd.tail == PW'(SLOTS - 1)) ? '0 : st_rd.tail + 1'b1;
                  ent_n.cnt   = st_rd.cnt + 1'b1;
                  ent_n.outst = st_rd.outst + 1'b1;
                  if (st_rd.lc == srrs_pkg::LC_IDLE) begin
                    ent_n.lc      = srrs_pkg::LC_SCHEDULED;
                    ent_n.pending = 1'b1;
                    push_req      = 1'b1;
                  end
                end
              end
              srrs_pkg::REQ_COMPLETE: begin
                if (32'(st_rd.cnt) - 32'(st_rd.outst) >= RESERVED_DEPTH ||
                    32'(st_rd.cnt) >= SLOTS) begin
                  status_d = srrs_pkg::ST_CPL_OVF;
                end else begin
                  op_we      = 1'b1;
                  op_wdata   = {srrs_pkg::KIND_COMPLETION, err_q, gen_q, handle_q};
                  ent_n.tail = (st_rd.tail == PW'(SLOTS - 1)) ? '0 : st_rd.tail + 1'b1;
                  ent_n.cnt  = st_rd.cnt + 1'b1;
                  if (!st_rd.pending) begin
                    ent_n.pending = 1'b1;
                    if (st_rd.lc == srrs_pkg::LC_IDLE) begin
                      ent_n.lc = srrs_pkg::LC_SCHEDULED;
                    end
                    push_req = 1'b1;
                  end
                end
              end
              srrs_pkg::REQ_QUIESCE: begin
                if (!st_rd.closing) begin
                  ent_n.closing = 1'b1;
                  ent_n.lc = (!st_rd.pending && st_rd.cnt == '0) ?
                             srrs_pkg::LC_STOPPED : srrs_pkg::LC_CLOSING;
                end
              end
              srrs_pkg::REQ_GEN_ADV: begin
                ent_n.gen = st_rd.gen + 8'd1;
              end
              default: begin
              end
            endcase
            sstat_d = ent_n.lc;
          end
        end
      end
      S_OP: begin
        state_d       = S_IDLE;
        done_d        = 1'b1;
        st_we         = 1'b1;
        st_waddr      = t_q;
        ent_n         = ent_q;
        ent_n.pending = 1'b0;
        ent_n.in_ring = 1'b0;
        head_base     = (ring_head_q == SW'(NUM_STRANDS - 1)) ? '0 : ring_head_q + 1'b1;
        cnt_base      = ring_cnt_q - 1'b1;
        ring_head_d   = head_base;
        ring_cnt_d    = cnt_base;
        have          = (ent_q.cnt != '0);
        if (have) begin
          ent_n.head = (ent_q.head == PW'(SLOTS - 1)) ? '0 : ent_q.head + 1'b1;
          ent_n.cnt  = ent_q.cnt - 1'b1;
        end
        if (ent_n.cnt != '0) begin
          ent_n.pending = 1'b1;
          ent_n.lc = ent_q.closing ? srrs_pkg::LC_CLOSING : srrs_pkg::LC_SCHEDULED;
          push_req = 1'b1;
        end else begin
          ent_n.lc = ent_q.closing ? srrs_pkg::LC_STOPPED : srrs_pkg::LC_IDLE;
        end
        rstrand_d = t_ext[3:0];
        if (have) begin
          fresh     = (op_rdata[39:32] == ent_q.gen);
          rhandle_d = op_rdata[31:0];
          if (op_rdata[48] == srrs_pkg::KIND_POST) begin
            if (ent_q.closing) begin
              action_d = srrs_pkg::ACT_CLEANUP;
            end else begin
              action_d = fresh ? srrs_pkg::ACT_INVOKE : srrs_pkg::ACT_STALE;
            end
            if (ent_q.outst != '0) begin
              ent_n.outst = ent_q.outst - 1'b1;
            end
          end else begin
            action_d = fresh ? srrs_pkg::ACT_COMPLETE : srrs_pkg::ACT_STALE_CPL;
            rerr_d   = op_rdata[47:40];
          end
        end
        sstat_d = ent_n.lc;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // append the strand at the ring tail
    tail_sum   = (RCW + 1)'(head_base) + (RCW + 1)'(cnt_base);
    if (32'(tail_sum) >= NUM_STRANDS) begin
      tail_sum = tail_sum - (RCW + 1)'(NUM_STRANDS);
    end
    ring_waddr = SW'(tail_sum);
    if (push_req) begin
      if (ent_n.in_ring) begin
        fault_d = 1'b1;
      end else if (32'(cnt_base) < NUM_STRANDS) begin
        ring_we       = 1'b1;
        ring_cnt_d    = cnt_base + 1'b1;
        ent_n.in_ring = 1'b1;
      end
    end
  end

  // ring write data is t_q, so hold the addressed strand there too
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ring_head_q <= '0;
      ring_cnt_q  <= '0;
      fault_q     <= 1'b0;
      op_limit_q  <= srrs_pkg::OP_LIMIT_RST;
      vld_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ring_head_q <= ring_head_d;
      ring_cnt_q  <= ring_cnt_d;
      fault_q     <= fault_d;
      done_q      <= done_d;
      if (op_limit_we_i) begin
        op_limit_q <= op_limit_i;
      end
      if (st_we) begin
        vld_q[st_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vld_rd_q  <= vld_q[st_raddr];
    status_q  <= status_d;
    action_q  <= action_d;
    rstrand_q <= rstrand_d;
    rhandle_q <= rhandle_d;
    rerr_q    <= rerr_d;
    sstat_q   <= sstat_d;
    if (accept) begin
      req_q    <= req_type_i;
      sid_q    <= strand_id_i;
      handle_q <= op_handle_i;
      gen_q    <= op_generation_i;
      err_q    <= completion_error_i;
      t_q      <= SW'(strand_id_i);
    end else if (state_q == S_RING) begin
      t_q <= ring_rdata;
    end
    if (state_q == S_STRAND) begin
      ent_q <= st_rd;
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign action_o          = action_q;
  assign run_strand_o      = rstrand_q;
  assign run_handle_o      = rhandle_q;
  assign run_error_o       = rerr_q;
  assign strand_status_o   = sstat_q;
  assign duplicate_fault_o = fault_q;

  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ring_cnt_q) <= NUM_STRANDS)
    else $error("ready ring count beyond strand count");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o || done_o)
    else $error("accepted item neither in progress nor answered");

  a_empty_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == srrs_pkg::ST_RING_EMPTY |-> action_o == srrs_pkg::ACT_NONE)
    else $error("empty ring result carries an action");

  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fault_q) |-> fault_q)
    else $error("duplicate fault cleared");

endmodule
`default_nettype wire

FILE: dv/strand_round_robin_scheduler_unit_test.sv
// Self-checking testbench for strand_round_robin_scheduler_unit.
// Depends on srrs_pkg; drives requests, predicts each result and compares field by field.
`default_nettype none
module strand_round_robin_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTR  = 16;
  localparam int OPD   = 8;
  localparam int RSVD  = 8;
  localparam int SLOTS = OPD + RSVD;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  action;
    logic [3:0]  strand;
    logic [31:0] handle;
    logic [7:0]  error;
    logic [2:0]  lifecycle;
    logic        fault;
  } sched_res_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [7:0]  gen;
    logic [7:0]  err;
    logic        kind;
  } op_t;

  typedef struct {
    logic [2:0]  req;
    logic [3:0]  sid;
    logic [31:0] handle;
    logic [7:0]  gen;
    logic [7:0]  err;
    logic        typed;
    sched_res_t  res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        op_limit_we_i = 1'b0;
  logic [3:0]  op_limit_i = '0;
  logic        start_i = 1'b0;
  logic [2:0]  req_type_i = '0;
  logic [3:0]  strand_id_i = '0;
  logic [31:0] op_handle_i = '0;
  logic [7:0]  op_generation_i = '0;
  logic [7:0]  completion_error_i = '0;
  logic        busy_o, done_o, duplicate_fault_o;
  logic [2:0]  status_o, action_o, strand_status_o;
  logic [3:0]  run_strand_o;
  logic [31:0] run_handle_o;
  logic [7:0]  run_error_o;

  strand_round_robin_scheduler_unit dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [3:0]  lim;
  logic [3:0]  ring [NSTR];
  int          rhead, rcount;
  logic [2:0]  life [NSTR];
  logic        closing [NSTR], pending [NSTR], inring [NSTR];
  logic [7:0]  curgen [NSTR];
  int          outst [NSTR];
  op_t         store [NSTR][SLOTS];
  int          fhead [NSTR], ftail [NSTR], fcount [NSTR];
  logic        fault;

  sched_res_t  expected_results [$];
  int          errors = 0, transfers = 0, checked = 0, runs_served = 0;
  int          send_idle = 20;

  function automatic void ring_append(int s);
    if (inring[s]) begin
      fault = 1'b1;
      return;
    end
    if (rcount >= NSTR) return;
    ring[(rhead + rcount) % NSTR] = s[3:0];
    rcount++;
    inring[s] = 1'b1;
  endfunction

  function automatic void queue_op(int s, op_t e);
    store[s][ftail[s]] = e;
    ftail[s] = (ftail[s] + 1) % SLOTS;
    fcount[s]++;
  endfunction

  function automatic sched_res_t schedule_step(logic [2:0] req, logic [3:0] sid,
                                              logic [31:0] h, logic [7:0] g, logic [7:0] er);
    sched_res_t r;
    op_t e;
    int t, s;
    logic have;
    r = '0;
    s = sid;
    if (req == srrs_pkg::REQ_RUN) begin
      if (rcount == 0) r.status = srrs_pkg::ST_RING_EMPTY;
      else begin
        t = ring[rhead];
        have = 1'b0;
        rhead = (rhead + 1) % NSTR;
        rcount--;
        inring[t] = 1'b0;
        pending[t] = 1'b0;
        if (fcount[t] > 0) begin
          e = store[t][fhead[t]];
          fhead[t] = (fhead[t] + 1) % SLOTS;
          fcount[t]--;
          have = 1'b1;
        end
        if (fcount[t] > 0) begin
          pending[t] = 1'b1;
          life[t] = closing[t] ? srrs_pkg::LC_CLOSING : srrs_pkg::LC_SCHEDULED;
          ring_append(t);
        end else life[t] = closing[t] ? srrs_pkg::LC_STOPPED : srrs_pkg::LC_IDLE;
        r.strand = t[3:0];
        if (have) begin
          r.handle = e.handle;
          if (e.kind == srrs_pkg::KIND_POST) begin
            if (closing[t]) r.action = srrs_pkg::ACT_CLEANUP;
            else r.action = (e.gen == curgen[t]) ? srrs_pkg::ACT_INVOKE : srrs_pkg::ACT_STALE;
            if (outst[t] > 0) outst[t]--;
          end else begin
            r.action = (e.gen == curgen[t]) ? srrs_pkg::ACT_COMPLETE : srrs_pkg::ACT_STALE_CPL;
            r.error = e.err;
          end
        end
        r.lifecycle = life[t];
      end
    end else begin
      case (req)
        srrs_pkg::REQ_POST: begin
          if (closing[s]) r.status = srrs_pkg::ST_STOPPING;
          else if (outst[s] >= lim || outst[s] >= OPD || fcount[s] >= SLOTS)
            r.status = srrs_pkg::ST_QUEUE_FULL;
          else begin
            queue_op(s, '{handle: h, gen: curgen[s], err: 8'h0, kind: srrs_pkg::KIND_POST});
            outst[s]++;
            if (life[s] == srrs_pkg::LC_IDLE) begin
              life[s] = srrs_pkg::LC_SCHEDULED;
              pending[s] = 1'b1;
              ring_append(s);
            end
          end
        end
        srrs_pkg::REQ_COMPLETE: begin
          if (fcount[s] - outst[s] >= RSVD || fcount[s] >= SLOTS)
            r.status = srrs_pkg::ST_CPL_OVF;
          else begin
            queue_op(s, '{handle: h, gen: g, err: er, kind: srrs_pkg::KIND_COMPLETION});
            if (!pending[s]) begin
              pending[s] = 1'b1;
              if (life[s] == srrs_pkg::LC_IDLE) life[s] = srrs_pkg::LC_SCHEDULED;
              ring_append(s);
            end
          end
        end
        srrs_pkg::REQ_QUIESCE: begin
          if (!closing[s]) begin
            closing[s] = 1'b1;
            life[s] = (!pending[s] && fcount[s] == 0) ? srrs_pkg::LC_STOPPED
                                                      : srrs_pkg::LC_CLOSING;
          end
        end
        srrs_pkg::REQ_GEN_ADV: curgen[s] = curgen[s] + 8'd1;
        default: ;
      endcase
      r.lifecycle = life[s];
    end
    r.fault = fault;
    return r;
  endfunction

  // hold start_i and the fields until the accepting edge; drop start_i only when idling
  task automatic send_request(logic [2:0] req, logic [3:0] sid, logic [31:0] h,
                              logic [7:0] g, logic [7:0] er, logic typed, sched_res_t tr);
    sched_res_t p;
    if ($urandom_range(99) < send_idle) begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_type_i <= req;
    strand_id_i <= sid;
    op_handle_i <= h;
    op_generation_i <= g;
    completion_error_i <= er;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    p = schedule_step(req, sid, h, g, er);
    if (typed && p !== tr) $display("directed row disagrees with predictor: %h vs %h", tr, p);
    expected_results.push_back(typed ? tr : p);
    transfers++;
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [3:0] v);
    drain();
    op_limit_we_i <= 1'b1;
    op_limit_i <= v;
    @(posedge clk_i);
    op_limit_we_i <= 1'b0;
    lim = v;
  endtask

  // result checker
  always @(posedge clk_i) begin
    sched_res_t got, want;
    if (rst_ni && done_o) begin
      got = '{status_o, action_o, run_strand_o, run_handle_o, run_error_o,
              strand_status_o, duplicate_fault_o};
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        checked++;
        if (got.action != srrs_pkg::ACT_NONE) runs_served++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"result %0d: st %0d/%0d act %0d/%0d strand %0d/%0d hdl %h/%h",
                      " err %h/%h lc %0d/%0d flt %b/%b"},
                     checked, want.status, got.status, want.action, got.action,
                     want.strand, got.strand, want.handle, got.handle, want.error, got.error,
                     want.lifecycle, got.lifecycle, want.fault, got.fault);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("strand_round_robin_scheduler_unit: mismatch");
    $finish;
  end

  stim_row_t rows [$];

  task automatic random_item(int focus);
    logic [2:0] req;
    logic [3:0] sid;
    int sel;
    sel = $urandom_range(99);
    if (sel < 38) req = srrs_pkg::REQ_POST;
    else if (sel < 55) req = srrs_pkg::REQ_COMPLETE;
    else if (sel < 58) req = srrs_pkg::REQ_QUIESCE;
    else if (sel < 92) req = srrs_pkg::REQ_RUN;
    else if (sel < 98) req = srrs_pkg::REQ_GEN_ADV;
    else req = 3'($urandom_range(7, 5));
    sid = ($urandom_range(3) != 0) ? 4'($urandom_range(focus)) : 4'($urandom);
    send_request(req, sid, $urandom, $urandom_range(1) ? curgen[sid] : 8'($urandom),
                 8'($urandom), 1'b0, '0);
  endtask

  initial begin
    for (int i = 0; i < NSTR; i++) begin
      life[i] = srrs_pkg::LC_IDLE; closing[i] = 0; pending[i] = 0; inring[i] = 0;
      curgen[i] = 0; outst[i] = 0; fhead[i] = 0; ftail[i] = 0; fcount[i] = 0;
      ring[i] = 0;
    end
    rhead = 0; rcount = 0; fault = 0; lim = srrs_pkg::OP_LIMIT_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: typed rows where the result is obvious
    rows.push_back('{srrs_pkg::REQ_RUN, 4'd0, '0, '0, '0, 1'b1,
                     '{srrs_pkg::ST_RING_EMPTY, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{srrs_pkg::REQ_POST, 4'd15, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1,
                     '{srrs_pkg::ST_OK, 0, 0, 0, 0, srrs_pkg::LC_SCHEDULED, 0}});
    rows.push_back('{srrs_pkg::REQ_COMPLETE, 4'd15, 32'h0, 8'h0, 8'hFF, 1'b0, '0});
    rows.push_back('{srrs_pkg::REQ_GEN_ADV, 4'd15, '0, '0, '0, 1'b0, '0});
    rows.push_back('{srrs_pkg::REQ_RUN, 4'd0, '0, '0, '0, 1'b1,
                     '{srrs_pkg::ST_OK, srrs_pkg::ACT_STALE, 4'd15, 32'hFFFF_FFFF, 0,
                       srrs_pkg::LC_SCHEDULED, 0}});
    rows.push_back('{srrs_pkg::REQ_RUN, 4'd0, '0, '0, '0, 1'b0, '0});
    rows.push_back('{srrs_pkg::REQ_POST, 4'd0, 32'h1234_5678, '0, '0, 1'b0, '0});
    rows.push_back('{srrs_pkg::REQ_COMPLETE, 4'd0, 32'hA5A5_0001, 8'h0, 8'h7E, 1'b0, '0});
    rows.push_back('{srrs_pkg::REQ_QUIESCE, 4'd0, '0, '0, '0, 1'b1,
                     '{srrs_pkg::ST_OK, 0, 0, 0, 0, srrs_pkg::LC_CLOSING, 0}});
    rows.push_back('{srrs_pkg::REQ_QUIESCE, 4'd0, '0, '0, '0, 1'b0, '0});
    rows.push_back('{srrs_pkg::REQ_POST, 4'd0, 32'h1, '0, '0, 1'b1,
                     '{srrs_pkg::ST_STOPPING, 0, 0, 0, 0, srrs_pkg::LC_CLOSING, 0}});
    rows.push_back('{srrs_pkg::REQ_RUN, 4'd0, '0, '0, '0, 1'b0, '0});
    rows.push_back('{srrs_pkg::REQ_RUN, 4'd0, '0, '0, '0, 1'b0, '0});
    rows.push_back('{srrs_pkg::REQ_QUIESCE, 4'd3, '0, '0, '0, 1'b1,
                     '{srrs_pkg::ST_OK, 0, 0, 0, 0, srrs_pkg::LC_STOPPED, 0}});
    rows.push_back('{3'd7, 4'd3, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1,
                     '{srrs_pkg::ST_OK, 0, 0, 0, 0, srrs_pkg::LC_STOPPED, 0}});
    rows.push_back('{3'd5, 4'd1, '0, '0, '0, 1'b0, '0});
    rows.push_back('{3'd6, 4'd2, '0, '0, '0, 1'b0, '0});
    for (int i = 0; i < rows.size(); i++)
      send_request(rows[i].req, rows[i].sid, rows[i].handle, rows[i].gen, rows[i].err,
                   rows[i].typed, rows[i].res);

    // limit 1 and overflow of the reserved completion slots on strand 5
    write_limit(4'd1);
    for (int i = 0; i < 3; i++)
      send_request(srrs_pkg::REQ_POST, 4'd5, 32'($urandom), 0, 0, 1'b0, '0);
    for (int i = 0; i < 10; i++)
      send_request(srrs_pkg::REQ_COMPLETE, 4'd5, 32'($urandom), 8'($urandom), 8'($urandom),
                   1'b0, '0);
    write_limit(4'd0);
    send_request(srrs_pkg::REQ_POST, 4'd6, 32'h0, 0, 0, 1'b0, '0);
    write_limit(4'd15);

    // random phases: varied limit and idling
    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 20 : (ph < 4) ? 57 : 0;
      if (ph == 1) write_limit(4'd8);
      else if (ph == 2) write_limit(4'd3);
      else if (ph == 3) write_limit(4'd15);
      else if (ph == 4) write_limit(4'd1);
      else if (ph == 5) write_limit(4'($urandom_range(15)));
      for (int i = 0; i < 300; i++) begin
        random_item((ph % 2 == 0) ? 3 : 15);
        if (i == 150) drain();
      end
    end
    drain();
    $display("%0d requests transferred, %0d results checked, %0d dispatching a handle",
             transfers, checked, runs_served);
    if (errors == 0 && expected_results.size() == 0)
      $display("strand_round_robin_scheduler_unit: match");
    else
      $display("strand_round_robin_scheduler_unit: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
